/* design/arc_pkg.sv */
// arc_pkg: shared types, widths and codes of the ARP responder cache.
// No dependencies; imported by the interfaces and every module but arc_ram.
`default_nettype none

package arc_pkg;

  // Field widths
  localparam int unsigned MAC_W      = 48;
  localparam int unsigned IP_W       = 32;
  localparam int unsigned OPC_W      = 16;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned USED_W     = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 48;

  // Table size default
  localparam int unsigned TABLE_ENTRIES_DEF = 16;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register reset
  localparam logic [IP_W-1:0] OWN_IP_RESET = 32'h0A00020E;  // 10.0.2.14

  // Request types
  localparam logic [REQ_W-1:0] REQ_PACKET = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  // ARP opcodes
  localparam logic [OPC_W-1:0] OPC_REQUEST = 16'd1;
  localparam logic [OPC_W-1:0] OPC_REPLY   = 16'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_STORED  = 3'd0,
    KIND_REPLY   = 3'd1,
    KIND_UNKNOWN = 3'd2,
    KIND_HIT     = 3'd3,
    KIND_MISS    = 3'd4,
    KIND_ADDED   = 3'd5
  } kind_e;

  typedef enum logic {
    OP_STORE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  // Classified command, front to back
  typedef struct packed {
    op_e               op;
    kind_e             kind;
    logic [MAC_W-1:0]  peer_mac;
    logic [IP_W-1:0]   peer_ip;
  } arc_cmd_t;

endpackage

`default_nettype wire

/* design/arc_ifs.sv */
// arc_ifs: valid/ready channel interfaces (input, result, configuration).
// Depends on arc_pkg.
`default_nettype none

interface arc_in_if import arc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic [OPC_W-1:0] opcode;
  logic [MAC_W-1:0] peer_mac;
  logic [IP_W-1:0]  peer_ip;
  logic [IP_W-1:0]  target_ip;

  modport source (output valid, req_type, opcode, peer_mac, peer_ip, target_ip,
                  input ready);
  modport sink   (input valid, req_type, opcode, peer_mac, peer_ip, target_ip,
                  output ready);
endinterface

interface arc_out_if import arc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [MAC_W-1:0]  reply_mac;
  logic [IP_W-1:0]   reply_ip;
  logic [MAC_W-1:0]  found_mac;
  logic [USED_W-1:0] entries_used;

  modport source (output valid, result_kind, reply_mac, reply_ip, found_mac,
                  entries_used, input ready);
  modport sink   (input valid, result_kind, reply_mac, reply_ip, found_mac,
                  entries_used, output ready);
endinterface

interface arc_cfg_if import arc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/arc_ram.sv */
// arc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module arc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* design/arc_front.sv */
// arc_front: accepts input transactions and classifies them into commands.
// Depends on arc_pkg and arc_ifs.
`default_nettype none

module arc_front import arc_pkg::*; (
  arc_in_if.sink           in_chan,
  input  wire logic [IP_W-1:0] own_ip_i,
  input  wire logic            full_i,
  output logic                 push_o,
  output arc_cmd_t             cmd_o
);

  assign in_chan.ready = !full_i;

  always_comb begin
    cmd_o.op       = OP_STORE;
    cmd_o.kind     = KIND_STORED;
    cmd_o.peer_mac = in_chan.peer_mac;
    cmd_o.peer_ip  = in_chan.peer_ip;
    push_o         = in_chan.valid && !full_i;
    case (in_chan.req_type)
      REQ_PACKET: begin
        if (in_chan.opcode == OPC_REQUEST) begin
          cmd_o.kind = (in_chan.target_ip == own_ip_i) ? KIND_REPLY : KIND_STORED;
        end else if (in_chan.opcode == OPC_REPLY) begin
          cmd_o.kind = KIND_STORED;
        end else begin
          cmd_o.kind = KIND_UNKNOWN;
        end
      end
      REQ_LOOKUP: begin
        cmd_o.op   = OP_LOOKUP;
        cmd_o.kind = KIND_MISS;
      end
      REQ_ADD: begin
        cmd_o.kind = KIND_ADDED;
      end
      default: begin
        // unused request type: taken and dropped
        push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* design/arc_queue.sv */
// arc_queue: short command FIFO between front and back.
// Depends on arc_pkg.
`default_nettype none

module arc_queue import arc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire arc_cmd_t push_cmd_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          empty_o,
  output arc_cmd_t      head_o
);

  arc_cmd_t          entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        entry_q[wr_ptr_q] <= push_cmd_i;
        wr_ptr_q          <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/arc_back.sv */
// arc_back: executes commands against the table; serial lookup walk.
// Depends on arc_pkg, arc_ifs and arc_ram.
`default_nettype none

module arc_back import arc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     empty_i,
  input  wire arc_cmd_t head_i,
  output logic          pop_o,
  arc_out_if.source     out_chan
);

  localparam int unsigned IW = $clog2(TABLE_ENTRIES);
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned EW = IP_W + MAC_W;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e                   state_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [IW-1:0]            next_slot_q, scan_idx_q;
  logic [UW-1:0]            used_q;
  logic                     chk_q, chk_vld_q, chk_last_q;
  logic [IP_W-1:0]          key_q;

  logic                     out_valid_q;
  kind_e                    kind_q;
  logic [MAC_W-1:0]         reply_mac_q, found_mac_q;
  logic [IP_W-1:0]          reply_ip_q;
  logic [USED_W-1:0]        used_out_q;

  logic                     take, ram_we, hit, miss, is_reply, scan_last;
  logic [EW-1:0]            rdata;
  logic [IP_W-1:0]          rd_ip;
  logic [MAC_W-1:0]         rd_mac;
  logic [UW-1:0]            used_inc;
  logic [31:0]              used_inc_ext, used_ext;
  logic [IW-1:0]            slot_nxt, scan_nxt;

  arc_ram #(
    .WIDTH (EW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (next_slot_q),
    .wdata_i ({head_i.peer_ip, head_i.peer_mac}),
    .raddr_i (scan_idx_q),
    .rdata_o (rdata)
  );

  assign rd_ip  = rdata[EW-1:MAC_W];
  assign rd_mac = rdata[MAC_W-1:0];

  assign take   = (state_q == S_IDLE) && !empty_i && !out_valid_q;
  assign pop_o  = take;
  assign ram_we = take && (head_i.op == OP_STORE);
  assign is_reply = (head_i.kind == KIND_REPLY);

  // previous read checked while the next one is issued
  assign hit  = chk_q && chk_vld_q && (rd_ip == key_q);
  assign miss = chk_q && !hit && chk_last_q;

  assign used_inc     = (used_q == UW'(TABLE_ENTRIES)) ? used_q : used_q + 1'b1;
  assign used_inc_ext = 32'(used_inc);
  assign used_ext     = 32'(used_q);
  assign slot_nxt     = (next_slot_q == IW'(TABLE_ENTRIES - 1)) ? '0 : next_slot_q + 1'b1;
  assign scan_last    = (scan_idx_q == IW'(TABLE_ENTRIES - 1));
  assign scan_nxt     = scan_last ? '0 : scan_idx_q + 1'b1;

  assign out_chan.valid        = out_valid_q;
  assign out_chan.result_kind  = kind_q;
  assign out_chan.reply_mac    = reply_mac_q;
  assign out_chan.reply_ip     = reply_ip_q;
  assign out_chan.found_mac    = found_mac_q;
  assign out_chan.entries_used = used_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      next_slot_q <= '0;
      used_q      <= '0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (take) begin
            if (head_i.op == OP_STORE) begin
              valid_q[next_slot_q] <= 1'b1;
              next_slot_q          <= slot_nxt;
              used_q               <= used_inc;
              out_valid_q          <= 1'b1;
              kind_q               <= head_i.kind;
              reply_mac_q          <= is_reply ? head_i.peer_mac : '0;
              reply_ip_q           <= is_reply ? head_i.peer_ip : '0;
              found_mac_q          <= '0;
              used_out_q           <= used_inc_ext[USED_W-1:0];
            end else begin
              key_q      <= head_i.peer_ip;
              scan_idx_q <= '0;
              chk_q      <= 1'b0;
              state_q    <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          chk_vld_q  <= valid_q[scan_idx_q];
          chk_last_q <= scan_last;
          scan_idx_q <= scan_nxt;
          if (hit || miss) begin
            out_valid_q <= 1'b1;
            kind_q      <= hit ? KIND_HIT : KIND_MISS;
            reply_mac_q <= '0;
            reply_ip_q  <= '0;
            found_mac_q <= hit ? rd_mac : '0;
            used_out_q  <= used_ext[USED_W-1:0];
            chk_q       <= 1'b0;
            state_q     <= S_IDLE;
          end else begin
            chk_q       <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* design/arp_responder_cache_core.sv */
// arp_responder_cache_core: top level of the ARP cache with request responder.
// Depends on arc_pkg, arc_ifs, arc_front, arc_queue, arc_back, arc_ram.
//
//   channel   dir  handshake      payload
//   in_chan   in   valid/ready    req_type, opcode, peer_mac, peer_ip, target_ip
//   out_chan  out  valid/ready    result_kind, reply_mac, reply_ip, found_mac,
//                                 entries_used
//   cfg_chan  in   valid/ready    index, data (0 own_ip, 1 own_mac)
//
// Flow: the front classifies a transaction in its accept cycle and queues it.
// Packet and add commands write the table and the result register as they are popped.
// A lookup walks the table RAM one entry per cycle through its single read
// port, from entry 0 up, and ends on the first hit or after the last entry.
// Reset: valid bits, counters and the queue clear at once; no clearing pass.
// Stalls: a two-deep queue and the result register let input be taken while a
// result waits; input stalls only when the queue is full.
`default_nettype none

module arp_responder_cache_core import arc_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  arc_in_if.sink     in_chan,
  arc_out_if.source  out_chan,
  arc_cfg_if.sink    cfg_chan
);

  // own_ip feeds the request compare. own_mac is the reply sender address,
  // used by the frame builder outside this block, so it is not held here.
  logic [IP_W-1:0] own_ip_q;

  logic     push, full, pop, empty;
  arc_cmd_t push_cmd, head;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_ip_q <= OWN_IP_RESET;
    end else if (cfg_chan.valid && (cfg_chan.index == CFG_OWN_IP)) begin
      own_ip_q <= cfg_chan.data[IP_W-1:0];
    end
  end

  arc_front u_front (
    .in_chan  (in_chan),
    .own_ip_i (own_ip_q),
    .full_i   (full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  arc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head)
  );

  arc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .head_i   (head),
    .pop_o    (pop),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  // unused request type must never reach the queue
  a_drop_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_chan.valid && in_chan.ready && (in_chan.req_type == REQ_UNUSED)) |-> !push)
    else $error("unused request type queued");

  // back end only starts a command into an empty result register
  a_pop_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !out_chan.valid)
    else $error("command started while result pending");

  // nothing is queued without a free slot
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue overflow");

  // reply address fields are zero unless the result is a reply
  a_reply_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_chan.valid && (out_chan.result_kind != KIND_REPLY)) |->
      ((out_chan.reply_ip == '0) && (out_chan.reply_mac == '0)))
    else $error("reply fields set on non-reply result");
`endif

endmodule

`default_nettype wire

/* tb/testbench.sv */
// testbench: self-checking bench for arp_responder_cache_core.
// Depends on arc_pkg and arc_ifs; drives the input and configuration channels
// and checks each result against a cycle-free model of the ARP table.
`timescale 1ns / 100ps

module testbench;
  import arc_pkg::*;

  localparam int unsigned TBL_SIZE   = 16;
  localparam int unsigned POOL_SIZE  = 12;
  // Quiet time after settling, before a register write; long enough for the worst lookup walk.
  localparam int unsigned QUIET_CYC  = 30;
  localparam int unsigned PHASE_ITEMS = 150;

  typedef struct {
    logic [REQ_W-1:0] req_type;
    logic [OPC_W-1:0] opcode;
    logic [MAC_W-1:0] peer_mac;
    logic [IP_W-1:0]  peer_ip;
    logic [IP_W-1:0]  target_ip;
  } arp_req_t;

  typedef struct {
    kind_e             kind;
    logic [MAC_W-1:0]  reply_mac;
    logic [IP_W-1:0]   reply_ip;
    logic [MAC_W-1:0]  found_mac;
    logic [USED_W-1:0] entries_used;
  } arp_res_t;

  logic clk;
  logic rst_n;

  arc_in_if  in_chan ();
  arc_out_if out_chan ();
  arc_cfg_if cfg_chan ();

  arp_responder_cache_core #(
    .TABLE_ENTRIES(TBL_SIZE)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .cfg_chan(cfg_chan)
  );

  // 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the block: registers and the ARP table.
  // ---------------------------------------------------------------------
  logic [IP_W-1:0]   own_ip_q  = OWN_IP_RESET;
  logic [MAC_W-1:0]  own_mac_q = '0;
  logic [IP_W-1:0]   tbl_ip    [TBL_SIZE];
  logic [MAC_W-1:0]  tbl_mac   [TBL_SIZE];
  bit                tbl_valid [TBL_SIZE];
  logic [USED_W-1:0] tbl_used  = '0;
  int unsigned       tbl_next  = 0;

  arp_req_t arp_reqs_q[$];     // requests waiting for the driver
  arp_res_t cache_results_q[$]; // results the block still owes us

  int unsigned mismatch_count = 0;

  // Handshake bookkeeping shared between the clocked processes
  bit in_fire   = 1'b0;   // input transaction at the last rising edge
  bit in_busy   = 1'b0;   // valid is up with an item not yet taken
  int in_gap    = 0;
  int out_gap   = 0;
  int hold_left = 0;      // long receiver hold-off, counted by the ready process
  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;

  logic [IP_W-1:0] ip_pool [POOL_SIZE];

  // Computes the result of one request and updates the shadow table.
  // Returns 0 for the unused request type, which the block ignores.
  function automatic bit arp_cache_predict(input arp_req_t rq, output arp_res_t r);
    bit hit;
    hit = 1'b0;
    r.kind         = KIND_STORED;
    r.reply_mac    = '0;
    r.reply_ip     = '0;
    r.found_mac    = '0;
    r.entries_used = '0;
    case (rq.req_type)
      REQ_PACKET: begin
        if (rq.opcode == OPC_REQUEST) begin
          if (rq.target_ip == own_ip_q) begin
            r.kind      = KIND_REPLY;
            r.reply_mac = rq.peer_mac;
            r.reply_ip  = rq.peer_ip;
          end
        end else if (rq.opcode != OPC_REPLY) begin
          r.kind = KIND_UNKNOWN;
        end
      end
      REQ_LOOKUP: begin
        // lowest valid matching slot wins
        r.kind = KIND_MISS;
        for (int i = 0; i < TBL_SIZE; i++) begin
          if (!hit && tbl_valid[i] && tbl_ip[i] == rq.peer_ip) begin
            hit         = 1'b1;
            r.kind      = KIND_HIT;
            r.found_mac = tbl_mac[i];
          end
        end
      end
      REQ_ADD: r.kind = KIND_ADDED;
      default: return 1'b0;
    endcase
    // packets (any opcode) and adds take the next slot round-robin
    if (rq.req_type != REQ_LOOKUP) begin
      tbl_ip[tbl_next]    = rq.peer_ip;
      tbl_mac[tbl_next]   = rq.peer_mac;
      tbl_valid[tbl_next] = 1'b1;
      tbl_next            = (tbl_next + 1) % TBL_SIZE;
      if (tbl_used < TBL_SIZE) tbl_used = tbl_used + 1'b1;
    end
    r.entries_used = tbl_used;
    return 1'b1;
  endfunction

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap(input bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic bit field_ok(input string name, input logic [MAC_W-1:0] want,
                                  input logic [MAC_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // Monitor: samples all three channels at the rising edge.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    arp_res_t want;
    arp_res_t predicted;
    bit       ok;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      // config first: writes only happen while the block is idle anyway
      if (cfg_chan.valid && cfg_chan.ready) begin
        if (cfg_chan.index == CFG_OWN_IP) own_ip_q = cfg_chan.data[IP_W-1:0];
        else own_mac_q = cfg_chan.data;
      end

      in_fire = in_chan.valid && in_chan.ready;
      if (in_fire) begin
        if (arp_cache_predict('{in_chan.req_type, in_chan.opcode, in_chan.peer_mac,
                                in_chan.peer_ip, in_chan.target_ip}, predicted))
          cache_results_q.push_back(predicted);
      end

      if (out_chan.valid && out_chan.ready) begin
        if (cache_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d", $time,
                   out_chan.result_kind);
          mismatch_count++;
        end else begin
          want = cache_results_q.pop_front();
          ok = field_ok("result_kind", MAC_W'(want.kind), MAC_W'(out_chan.result_kind));
          ok = field_ok("reply_mac", want.reply_mac, out_chan.reply_mac) && ok;
          ok = field_ok("reply_ip", MAC_W'(want.reply_ip), MAC_W'(out_chan.reply_ip)) && ok;
          ok = field_ok("found_mac", want.found_mac, out_chan.found_mac) && ok;
          ok = field_ok("entries_used", MAC_W'(want.entries_used),
                        MAC_W'(out_chan.entries_used)) && ok;
          if (!ok) mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Driver: presents queued requests at the falling edge.
  // valid stays high across back-to-back transactions (one NBA per edge).
  // ---------------------------------------------------------------------
  always @(negedge clk) begin : driver
    arp_req_t rq;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_busy && in_fire) begin
        in_busy = 1'b0;
        in_gap  = pick_gap(in_idle_on);
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_chan.valid <= 1'b0;
        end else if (arp_reqs_q.size() != 0) begin
          rq = arp_reqs_q.pop_front();
          in_chan.req_type  <= rq.req_type;
          in_chan.opcode    <= rq.opcode;
          in_chan.peer_mac  <= rq.peer_mac;
          in_chan.peer_ip   <= rq.peer_ip;
          in_chan.target_ip <= rq.target_ip;
          in_chan.valid     <= 1'b1;
          in_busy = 1'b1;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random stalls, plus the long hold-off when requested.
  always @(negedge clk) begin : result_sink
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= 1'b1;
      out_gap = pick_gap(out_idle_on);
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic push_req(input logic [REQ_W-1:0] rt, input logic [OPC_W-1:0] opc,
                          input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip,
                          input logic [IP_W-1:0] tgt);
    arp_reqs_q.push_back('{rt, opc, mac, ip, tgt});
  endtask

  // Wait until every request is taken and every result is back, then let
  // an ignored request or a long lookup walk finish.
  task automatic settle();
    while (arp_reqs_q.size() != 0 || in_busy || cache_results_q.size() != 0)
      @(posedge clk);
    repeat (QUIET_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    cfg_chan.valid <= 1'b1;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid <= 1'b0;
  endtask

  // own_ip with junk in the unused upper data bits
  task automatic write_own_ip(input logic [IP_W-1:0] ip);
    logic [CFG_DATA_W-1:0] word;
    word = {CFG_DATA_W{1'b0}};
    word[CFG_DATA_W-1:IP_W] = (CFG_DATA_W-IP_W)'($urandom);
    word[IP_W-1:0] = ip;
    write_reg(CFG_OWN_IP, word);
  endtask

  task automatic refill_pool();
    ip_pool[0] = own_ip_q;
    ip_pool[1] = '0;
    ip_pool[2] = '1;
    for (int i = 3; i < POOL_SIZE; i++) ip_pool[i] = $urandom;
  endtask

  // Mostly well-formed traffic over a small IP pool so that lookups hit,
  // overwrites collide and requests often target our own address.
  function automatic arp_req_t random_req();
    arp_req_t rq;
    int roll;
    roll = $urandom_range(0, 99);
    rq.req_type = (roll < 45) ? REQ_PACKET : (roll < 75) ? REQ_LOOKUP :
                  (roll < 95) ? REQ_ADD : REQ_UNUSED;
    roll = $urandom_range(0, 99);
    rq.opcode = (roll < 60) ? OPC_REQUEST : (roll < 85) ? OPC_REPLY : OPC_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 4) rq.peer_mac = '0;
    else if (roll < 8) rq.peer_mac = '1;
    else begin
      rq.peer_mac[MAC_W-1:32] = (MAC_W-32)'($urandom);
      rq.peer_mac[31:0]       = $urandom;
    end
    rq.peer_ip = ($urandom_range(0, 3) != 0) ? ip_pool[$urandom_range(0, POOL_SIZE-1)]
                                            : $urandom;
    roll = $urandom_range(0, 2);
    rq.target_ip = (roll == 0) ? own_ip_q :
                   (roll == 1) ? ip_pool[$urandom_range(0, POOL_SIZE-1)] : $urandom;
    return rq;
  endfunction

  // Queues count requests that get a result; a pause mid-way lets the block
  // drain completely before the second half.
  task automatic run_random(input int count);
    arp_req_t rq;
    int sent;
    sent = 0;
    while (sent < count) begin
      rq = random_req();
      arp_reqs_q.push_back(rq);
      if (rq.req_type != REQ_UNUSED) sent++;
      if (sent == count / 2 && rq.req_type != REQ_UNUSED) settle();
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    logic [MAC_W-1:0] mac48;
    for (int i = 0; i < TBL_SIZE; i++) begin
      tbl_ip[i]    = '0;
      tbl_mac[i]   = '0;
      tbl_valid[i] = 1'b0;
    end
    rst_n = 1'b0;
    in_chan.valid     = 1'b0;
    in_chan.req_type  = '0;
    in_chan.opcode    = '0;
    in_chan.peer_mac  = '0;
    in_chan.peer_ip   = '0;
    in_chan.target_ip = '0;
    out_chan.ready    = 1'b0;
    cfg_chan.valid    = 1'b0;
    cfg_chan.index    = '0;
    cfg_chan.data     = '0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Directed part, reset register values (own IP 10.0.2.14)
    push_req(REQ_LOOKUP, OPC_REQUEST, '0, '0, '0);            // empty table: miss
    push_req(REQ_UNUSED, '1, '1, '1, '1);                     // ignored, no result
    push_req(REQ_PACKET, OPC_REQUEST, '1, '1, OWN_IP_RESET);  // request for us: reply
    push_req(REQ_PACKET, OPC_REQUEST, '0, '0, OWN_IP_RESET + 1); // other target
    push_req(REQ_PACKET, OPC_REPLY, 48'h0000_1111_2222, 32'h0A00_0201, OWN_IP_RESET);
    push_req(REQ_PACKET, 16'h0000, 48'h0102_0304_0506, 32'h0A00_0203, OWN_IP_RESET);
    push_req(REQ_PACKET, 16'hFFFF, 48'h0A0B_0C0D_0E0F, 32'h0A00_0204, '0);
    push_req(REQ_PACKET, 16'h0003, 48'h1234_5678_9ABC, 32'h0A00_0205, '1);
    push_req(REQ_ADD, '0, 48'hAAAA_AAAA_AAAA, 32'h0A00_0202, '0);
    push_req(REQ_ADD, '1, 48'h5555_5555_5555, 32'h0A00_0202, '1); // duplicate IP
    push_req(REQ_LOOKUP, '1, '1, 32'h0A00_0202, '1);          // lower slot wins
    push_req(REQ_LOOKUP, '0, '0, '1, '0);                     // all-ones IP hit
    push_req(REQ_LOOKUP, '0, '0, '0, '0);                     // zero IP hit
    push_req(REQ_LOOKUP, '0, '0, 32'h1234_5678, '0);          // miss on full walk
    push_req(REQ_UNUSED, '0, '0, '0, '0);
    // overfill: the table wraps and the all-ones entry in slot 0 goes away
    for (int i = 0; i < 9; i++) begin
      mac48 = {16'hC0DE, 32'(i)};
      push_req(REQ_ADD, '0, mac48, 32'hC0A8_0000 + i, '0);
    end
    push_req(REQ_LOOKUP, '0, '0, '1, '0);
    settle();

    // Own IP zero, own MAC all ones
    write_own_ip('0);
    write_reg(CFG_OWN_MAC, '1);
    refill_pool();
    run_random(PHASE_ITEMS);
    settle();

    // Own IP all ones; long receiver hold-off while the sender floods
    write_own_ip('1);
    write_reg(CFG_OWN_MAC, '0);
    refill_pool();
    in_idle_on = 1'b0;
    hold_left  = 400;
    run_random(PHASE_ITEMS);
    settle();
    in_idle_on = 1'b1;

    // Random addresses, idling on both sides
    write_own_ip($urandom);
    mac48[MAC_W-1:32] = (MAC_W-32)'($urandom);
    mac48[31:0]       = $urandom;
    write_reg(CFG_OWN_MAC, mac48);
    refill_pool();
    run_random(PHASE_ITEMS);
    settle();

    // Back to the default address, no idling at all
    write_own_ip(OWN_IP_RESET);
    refill_pool();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    run_random(PHASE_ITEMS);
    settle();

    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: well above the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
